[rtl/dcrgb_pkg.sv]
// Package for the daisy-chain RGB frame node.
// Holds frame position codes, the queue entry type and queue sizing.
// No dependencies.
package dcrgb_pkg;

  localparam logic [7:0] POS_LEN           = 8'd0;
  localparam logic [7:0] POS_RED           = 8'd1;
  localparam logic [7:0] POS_GREEN         = 8'd2;
  localparam logic [7:0] POS_BLUE          = 8'd3;
  localparam logic [7:0] POS_FIRST_PAYLOAD = 8'd4;
  localparam logic [7:0] HEADER_DROP       = 8'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified input item, as handed from front to back.
  typedef struct packed {
    logic       two;        // item expands into a length byte plus payload byte
    logic       fwd;
    logic [7:0] data;       // zero when fwd is low
    logic [7:0] newlen;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       receiving;
  } entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

[rtl/dcrgb_front.sv]
// Front part: accepts input items, tracks frame position and duty levels,
// and writes one classified entry per item. Depends on dcrgb_pkg.
module dcrgb_front
  import dcrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_byte,
  input  q_stat_t    q_stat,
  output logic       q_wr,
  output entry_t     q_entry
);

  logic [7:0] pos;
  logic [7:0] len;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  logic [7:0] pos_next;
  logic [7:0] len_next;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic       fwd;
  logic [8:0] inc;

  assign q_wr = push && !q_stat.full;

  always_comb begin
    len_next   = len;
    red_next   = red;
    green_next = green;
    blue_next  = blue;
    fwd        = 1'b0;
    case (pos)
      POS_LEN:   len_next   = rx_byte;
      POS_RED:   red_next   = rx_byte;
      POS_GREEN: green_next = rx_byte;
      POS_BLUE:  blue_next  = rx_byte;
      default:   fwd        = 1'b1;
    endcase
    inc = {1'b0, pos} + 9'd1;
    if (inc >= {1'b0, len_next}) begin
      pos_next = 8'd0;
    end else begin
      pos_next = inc[7:0];
    end
  end

  always_comb begin
    q_entry.two       = fwd && (pos == POS_FIRST_PAYLOAD);
    q_entry.fwd       = fwd;
    q_entry.data      = fwd ? rx_byte : 8'd0;
    q_entry.newlen    = len_next - HEADER_DROP;
    q_entry.red       = red_next;
    q_entry.green     = green_next;
    q_entry.blue      = blue_next;
    q_entry.receiving = (pos_next != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 8'd0;
      len   <= 8'd0;
      red   <= 8'd0;
      green <= 8'd0;
      blue  <= 8'd0;
    end else if (q_wr) begin
      pos   <= pos_next;
      len   <= len_next;
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

[rtl/dcrgb_queue.sv]
// Short register queue of classified entries between front and back.
// Depends on dcrgb_pkg.
module dcrgb_queue
  import dcrgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  entry_t  wr_entry,
  input  logic    rd,
  output entry_t  head,
  output q_stat_t stat
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign stat.full     = (count == QCNT_W'(QDEPTH));
  assign stat.nonempty = (count != '0);
  assign do_wr         = wr && !stat.full;
  assign do_rd         = rd && stat.nonempty;
  assign head          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == QCNT_W'(QDEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");
`endif

endmodule

[rtl/dcrgb_back.sv]
// Back part: expands queue entries into one or two result items and holds
// the current result in an output register. Depends on dcrgb_pkg.
module dcrgb_back
  import dcrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  q_stat_t    q_stat,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic       fwd_valid,
  output logic [7:0] fwd_byte,
  output logic       last,
  output logic [7:0] red_duty,
  output logic [7:0] green_duty,
  output logic [7:0] blue_duty,
  output logic       receiving
);

  logic out_valid;
  logic phase;     // first half of a two-result entry is in the output register
  logic load;
  logic first_half;

  assign empty      = !out_valid;
  assign load       = !out_valid || pop;
  assign first_half = head.two && !phase;
  assign q_rd       = load && q_stat.nonempty && !first_half;

  always_ff @(posedge clk) begin
    if (load && q_stat.nonempty) begin
      fwd_valid  <= head.fwd;
      fwd_byte   <= first_half ? head.newlen : head.data;
      last       <= !first_half;
      red_duty   <= head.red;
      green_duty <= head.green;
      blue_duty  <= head.blue;
      receiving  <= head.receiving;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= q_stat.nonempty;
      if (q_stat.nonempty) begin
        phase <= first_half;
      end
    end
  end

`ifndef SYNTH
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> q_stat.nonempty && head.two)
    else $error("second half pending without its entry");
  a_phase_first: assert property (@(posedge clk) disable iff (rst)
    phase |-> out_valid && !last && fwd_valid)
    else $error("pending second half but output is not the length item");
  a_first_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> phase)
    else $error("non-last item without pending second half");
`endif

endmodule

[rtl/daisy_chain_rgb_frame_node_core.sv]
// Top level of the daisy-chain RGB frame node: front, queue and back.
// Depends on dcrgb_pkg, dcrgb_front, dcrgb_queue, dcrgb_back.
//
//   channel  | handshake        | fields
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | rx_byte
//   result   | empty / pop      | fwd_valid fwd_byte last red_duty green_duty
//            |                  | blue_duty receiving
//
// An accepted item passes the queue, then the back unit's output register.
// The back unit emits one result per cycle while not stalled: byte 4 of a
// frame yields two results, held as one queue entry; all other items yield one.
// Reset (rst, synchronous) clears frame position, length, duty levels and queue.
// full rises when the two-entry queue fills while the result side stalls.
module daisy_chain_rgb_frame_node_core
  import dcrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       fwd_valid,
  output logic [7:0] fwd_byte,
  output logic       last,
  output logic [7:0] red_duty,
  output logic [7:0] green_duty,
  output logic [7:0] blue_duty,
  output logic       receiving
);

  q_stat_t q_stat;
  entry_t  q_entry;
  entry_t  q_head;
  logic    q_wr;
  logic    q_rd;

  assign full = q_stat.full;

  dcrgb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .q_stat  (q_stat),
    .q_wr    (q_wr),
    .q_entry (q_entry)
  );

  dcrgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_entry),
    .rd       (q_rd),
    .head     (q_head),
    .stat     (q_stat)
  );

  dcrgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .fwd_valid  (fwd_valid),
    .fwd_byte   (fwd_byte),
    .last       (last),
    .red_duty   (red_duty),
    .green_duty (green_duty),
    .blue_duty  (blue_duty),
    .receiving  (receiving)
  );

endmodule
